FILE: hw/rtl/euler_circuit_finder_macros.svh
// ---------------------------------------------------------------------------
// Euler circuit finder assertion macros
// Concurrent assertion wrappers; NO_ASSERTIONS compiles them away.
// ---------------------------------------------------------------------------
`ifndef EULER_CIRCUIT_FINDER_MACROS_SVH
`define EULER_CIRCUIT_FINDER_MACROS_SVH
`ifndef NO_ASSERTIONS
`define ECF_ASSERT(lbl, prop, msg) lbl: assert property (@(posedge clock) \
   disable iff (reset) prop) else $error(msg);
`define ECF_NEVER(lbl, cond, msg) lbl: assert property (@(posedge clock) \
   disable iff (reset) !(cond)) else $error(msg);
`else
`define ECF_ASSERT(lbl, prop, msg)
`define ECF_NEVER(lbl, cond, msg)
`endif
`endif

FILE: hw/rtl/ecf_pkg.sv
// ---------------------------------------------------------------------------
// Euler circuit finder package
// Word types, op codes and the command/status bundles between units.
// ---------------------------------------------------------------------------
package ecf_pkg;

   localparam int VERTEX_W = 4;
   localparam int COUNT_W  = 5;

   localparam logic [1:0] OP_ADD   = 2'd0;
   localparam logic [1:0] OP_RUN   = 2'd1;
   localparam logic [1:0] OP_CLEAR = 2'd2;

   typedef struct packed {
      logic [1:0]          op;
      logic [VERTEX_W-1:0] first_end;
      logic [VERTEX_W-1:0] second_end;
      logic [VERTEX_W-1:0] start_vertex;
   } req_type;

   typedef struct packed {
      logic [VERTEX_W-1:0] vertex;
      logic                found;
      logic                last;
   } rsp_type;

   typedef struct packed {
      logic edge_load;
      logic clear_edges;
      logic run_init;
      logic edge_rd;
      logic par_apply;
      logic scan_start;
      logic scan_apply;
      logic pop;
      logic pop_load;
      logic out_rd;
      logic out_emit;
      logic emit_fail;
      logic emit_single;
   } cmd_type;

   typedef struct packed {
      logic pre_fail;
      logic pre_single;
      logic edge_end;
      logic hit;
      logic par_bad;
      logic sp_one;
      logic all_used;
      logic out_last;
   } sts_type;

endpackage

FILE: hw/rtl/euler_circuit_finder.sv
// ---------------------------------------------------------------------------
// Euler circuit finder
// Loads undirected edges and emits a Hierholzer circuit vertex by vertex.
// ---------------------------------------------------------------------------
// channel   ports                               handshake
// request   start, busy, req_data               start && !busy
// response  rsp_strobe, rsp_data                one-cycle strobe
// config    csr_write_enable, csr_write_data    write enable
//
// Add and clear do not leave idle; busy stays low for them.
// A run makes a parity pass over the edge store, then the walk, each edge visit
// going through a read (SCAN_RD) and a check (SCAN_CHK) on the edge store read port,
// then the unused-edge check and a read and an emit per circuit word.
// The receiver cannot stall; busy holds the input off for the whole run.
// Reset is synchronous; no clearing pass.
// ---------------------------------------------------------------------------
module euler_circuit_finder #(
   parameter int MAX_VERTICES = 16,
   parameter int MAX_EDGES    = 32
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   output logic                        busy,
   input  ecf_pkg::req_type            req_data,
   output logic                        rsp_strobe,
   output ecf_pkg::rsp_type            rsp_data,
   input  logic                        csr_write_enable,
   input  logic [ecf_pkg::COUNT_W-1:0] csr_write_data
);

   ecf_pkg::cmd_type cmd;
   ecf_pkg::sts_type sts;
   logic             busy_int;
   logic             req_accept;

   assign req_accept = start && !busy_int;
   assign busy       = busy_int;

   ecf_ctrl u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .start  (req_accept),
      .req_op (req_data.op),
      .sts    (sts),
      .cmd    (cmd),
      .busy   (busy_int)
   );

   ecf_datapath #(
      .MAX_VERTICES (MAX_VERTICES),
      .MAX_EDGES    (MAX_EDGES)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .req_data         (req_data),
      .cmd              (cmd),
      .sts              (sts),
      .rsp_strobe       (rsp_strobe),
      .rsp_data         (rsp_data)
   );

endmodule

FILE: hw/rtl/ecf_ctrl.sv
// ---------------------------------------------------------------------------
// Euler circuit finder controller
// Sequences parity check, stack walk and circuit readout.
// ---------------------------------------------------------------------------
module ecf_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [1:0]       req_op,
   input  ecf_pkg::sts_type sts,
   output ecf_pkg::cmd_type cmd,
   output logic             busy
);

   typedef enum logic [3:0] {
      IDLE, PAR_RD, PAR_CHK, PAR_TEST, SCAN_RD, SCAN_CHK, POP_LOAD,
      DONE_CHK, OUT_RD, OUT_EMIT
   } state_type;

   state_type state_ff, state_in;

   assign busy = (state_ff != IDLE);

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         IDLE: begin
            if (start) begin
               unique case (req_op)
                  ecf_pkg::OP_ADD:   cmd.edge_load = 1'b1;
                  ecf_pkg::OP_CLEAR: cmd.clear_edges = 1'b1;
                  ecf_pkg::OP_RUN: begin
                     if (sts.pre_fail) begin
                        cmd.emit_fail = 1'b1;
                     end else if (sts.pre_single) begin
                        cmd.emit_single = 1'b1;
                     end else begin
                        cmd.run_init = 1'b1;
                        state_in     = PAR_RD;
                     end
                  end
                  default: ;
               endcase
            end
         end
         PAR_RD: begin
            if (sts.edge_end) begin
               state_in = PAR_TEST;
            end else begin
               cmd.edge_rd = 1'b1;
               state_in    = PAR_CHK;
            end
         end
         PAR_CHK: begin
            cmd.par_apply = 1'b1;
            state_in      = PAR_RD;
         end
         PAR_TEST: begin
            if (sts.par_bad) begin
               cmd.emit_fail = 1'b1;
               state_in      = IDLE;
            end else begin
               cmd.scan_start = 1'b1;
               state_in       = SCAN_RD;
            end
         end
         SCAN_RD: begin
            if (sts.edge_end) begin
               cmd.pop  = 1'b1;
               state_in = sts.sp_one ? DONE_CHK : POP_LOAD;
            end else begin
               cmd.edge_rd = 1'b1;
               state_in    = SCAN_CHK;
            end
         end
         SCAN_CHK: begin
            cmd.scan_apply = 1'b1;
            state_in       = SCAN_RD;
         end
         POP_LOAD: begin
            cmd.pop_load = 1'b1;
            state_in     = SCAN_RD;
         end
         DONE_CHK: begin
            if (sts.all_used) begin
               state_in = OUT_RD;
            end else begin
               cmd.emit_fail = 1'b1;
               state_in      = IDLE;
            end
         end
         OUT_RD: begin
            cmd.out_rd = 1'b1;
            state_in   = OUT_EMIT;
         end
         OUT_EMIT: begin
            cmd.out_emit = 1'b1;
            state_in     = sts.out_last ? IDLE : OUT_RD;
         end
         default: state_in = IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

FILE: hw/rtl/ecf_datapath.sv
// ---------------------------------------------------------------------------
// Euler circuit finder datapath
// Edge store, parity vector, walk stack, circuit buffer and result word.
// ---------------------------------------------------------------------------
`include "euler_circuit_finder_macros.svh"

module ecf_datapath #(
   parameter int MAX_VERTICES = 16,
   parameter int MAX_EDGES    = 32
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_write_enable,
   input  logic [ecf_pkg::COUNT_W-1:0]     csr_write_data,
   input  ecf_pkg::req_type                req_data,
   input  ecf_pkg::cmd_type                cmd,
   output ecf_pkg::sts_type                sts,
   output logic                            rsp_strobe,
   output ecf_pkg::rsp_type                rsp_data
);

   localparam int VIW = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
   localparam int NW  = ($clog2(MAX_VERTICES + 1) > ecf_pkg::COUNT_W) ?
                        $clog2(MAX_VERTICES + 1) : ecf_pkg::COUNT_W;
   localparam int AW  = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
   localparam int EW  = $clog2(MAX_EDGES + 1);
   localparam int SW  = $clog2(MAX_EDGES + 2);
   localparam int BD  = MAX_EDGES + 1;
   localparam int VW  = ecf_pkg::VERTEX_W;

   logic [ecf_pkg::COUNT_W-1:0] vcount_ff;
   logic [NW-1:0]               n_val, vc_ext;
   logic [EW-1:0]               total_ff, e_ff;
   logic                        reject_ff, bad_ff;
   logic [2*VW-1:0]             edge_mem [MAX_EDGES];
   logic [2*VW-1:0]             edge_rd_ff;
   logic [MAX_EDGES-1:0]        used_ff;
   logic [MAX_VERTICES-1:0]     par_ff, par_in;
   logic [VW-1:0]               top_ff, stack_rd_ff, buf_rd_ff;
   logic [VW-1:0]               stack_mem [MAX_EDGES];
   logic [VW-1:0]               buf_mem [BD];
   logic [SW-1:0]               sp_ff, cnt_ff, o_ff;
   logic                        rsp_strobe_ff;
   ecf_pkg::rsp_type            rsp_ff;
   logic [VW-1:0]               rd_a, rd_b, nxt;
   logic                        add_bad, used_cur, hit_a, hit_b, range_bad;
   logic                        unused_any, out_last;

   assign vc_ext   = NW'(vcount_ff);
   assign n_val    = (vc_ext > NW'(MAX_VERTICES)) ? NW'(MAX_VERTICES) : vc_ext;
   assign add_bad  = (NW'(req_data.first_end) >= n_val) ||
                     (NW'(req_data.second_end) >= n_val) ||
                     (total_ff == EW'(MAX_EDGES));
   assign rd_a      = edge_rd_ff[2*VW-1:VW];
   assign rd_b      = edge_rd_ff[VW-1:0];
   assign used_cur  = used_ff[e_ff[AW-1:0]];
   assign hit_a     = !used_cur && (rd_a == top_ff);
   assign hit_b     = !used_cur && (rd_b == top_ff);
   assign nxt       = hit_a ? rd_b : rd_a;
   assign range_bad = (NW'(rd_a) >= n_val) || (NW'(rd_b) >= n_val);
   assign out_last  = (SW'(o_ff + SW'(1)) == cnt_ff);

   always_comb begin
      par_in = par_ff;
      par_in[VIW'(rd_a)] = ~par_in[VIW'(rd_a)];
      par_in[VIW'(rd_b)] = ~par_in[VIW'(rd_b)];
   end

   always_comb begin
      unused_any = 1'b0;
      for (int i = 0; i < MAX_EDGES; i++) begin
         unused_any = unused_any || ((EW'(i) < total_ff) && !used_ff[i]);
      end
   end

   always_comb begin
      sts.pre_fail   = (n_val == '0) || reject_ff ||
                       ((total_ff == '0) && (n_val > NW'(1))) ||
                       ((total_ff != '0) && (NW'(req_data.start_vertex) >= n_val));
      sts.pre_single = (total_ff == '0);
      sts.edge_end   = (e_ff == total_ff);
      sts.hit        = hit_a || hit_b;
      sts.par_bad    = bad_ff || (|par_ff);
      sts.sp_one     = (sp_ff == SW'(1));
      sts.all_used   = !unused_any;
      sts.out_last   = out_last;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vcount_ff     <= '0;
         total_ff      <= '0;
         reject_ff     <= 1'b0;
         sp_ff         <= '0;
         cnt_ff        <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         if (csr_write_enable) begin
            vcount_ff <= csr_write_data;
         end
         if (cmd.edge_load) begin
            if (add_bad) begin
               reject_ff <= 1'b1;
            end else begin
               total_ff <= total_ff + EW'(1);
            end
         end
         if (cmd.clear_edges) begin
            total_ff  <= '0;
            reject_ff <= 1'b0;
         end
         if (cmd.run_init) begin
            sp_ff  <= SW'(1);
            cnt_ff <= '0;
         end
         if (cmd.scan_apply && sts.hit) begin
            sp_ff <= sp_ff + SW'(1);
         end
         if (cmd.pop) begin
            sp_ff  <= sp_ff - SW'(1);
            cnt_ff <= cnt_ff + SW'(1);
         end
         rsp_strobe_ff <= cmd.emit_fail || cmd.emit_single || cmd.out_emit;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.edge_load && !add_bad) begin
         edge_mem[total_ff[AW-1:0]] <= {req_data.first_end, req_data.second_end};
      end
      if (cmd.edge_rd) begin
         edge_rd_ff <= edge_mem[e_ff[AW-1:0]];
      end
      if (cmd.run_init) begin
         e_ff    <= '0;
         used_ff <= '0;
         par_ff  <= '0;
         bad_ff  <= 1'b0;
         top_ff  <= req_data.start_vertex;
         o_ff    <= '0;
      end
      if (cmd.par_apply) begin
         par_ff <= par_in;
         if (range_bad) begin
            bad_ff <= 1'b1;
         end
         e_ff <= e_ff + EW'(1);
      end
      if (cmd.scan_start || cmd.pop_load) begin
         e_ff <= '0;
      end
      if (cmd.scan_apply) begin
         if (sts.hit) begin
            used_ff[e_ff[AW-1:0]]             <= 1'b1;
            stack_mem[AW'(sp_ff - SW'(1))]    <= top_ff;
            top_ff                            <= nxt;
            e_ff                              <= '0;
         end else begin
            e_ff <= e_ff + EW'(1);
         end
      end
      if (cmd.pop) begin
         buf_mem[cnt_ff[EW-1:0]] <= top_ff;
         stack_rd_ff             <= stack_mem[AW'(sp_ff - SW'(2))];
      end
      if (cmd.pop_load) begin
         top_ff <= stack_rd_ff;
      end
      if (cmd.out_rd) begin
         buf_rd_ff <= buf_mem[o_ff[EW-1:0]];
      end
      if (cmd.out_emit) begin
         o_ff   <= o_ff + SW'(1);
         rsp_ff <= '{vertex: buf_rd_ff, found: 1'b1, last: out_last};
      end
      if (cmd.emit_fail) begin
         rsp_ff <= '{vertex: '0, found: 1'b0, last: 1'b1};
      end
      if (cmd.emit_single) begin
         rsp_ff <= '{vertex: '0, found: 1'b1, last: 1'b1};
      end
   end

   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_data   = rsp_ff;

   `ECF_NEVER(a_total_range, total_ff > EW'(MAX_EDGES), "edge count above capacity")
   `ECF_NEVER(a_stack_range, sp_ff > SW'(MAX_EDGES + 1), "walk stack overflow")
   `ECF_ASSERT(a_fail_last, rsp_strobe_ff && !rsp_ff.found |-> rsp_ff.last, "fail word not last")

endmodule

FILE: tb/euler_circuit_finder_test.sv
// ---------------------------------------------------------------------------
// Euler circuit finder testbench
// Loads edge lists, runs circuit searches and checks every emitted circuit
// word against an in-bench Hierholzer predictor, with random sender gaps.
// ---------------------------------------------------------------------------
module euler_circuit_finder_test;

   localparam logic [1:0] OP_UNUSED = 2'd3;
   localparam int         EDGE_CAP  = 32;
   localparam int         VERT_CAP  = 16;

   class circuit_scoreboard;
      logic [4:0]       vcount;
      logic [3:0]       end_a [EDGE_CAP];
      logic [3:0]       end_b [EDGE_CAP];
      int               edge_count;
      bit               rejected;
      ecf_pkg::rsp_type circuit_q [$];
      int               errors;

      function new();
         vcount = 0;
         edge_count = 0;
         rejected = 0;
         errors = 0;
      endfunction

      function int live();
         return (vcount > VERT_CAP) ? VERT_CAP : int'(vcount);
      endfunction

      function int pending();
         return circuit_q.size();
      endfunction

      function void push(logic [3:0] v, logic f, logic l);
         ecf_pkg::rsp_type w;
         w.vertex = v;
         w.found = f;
         w.last = l;
         circuit_q = {circuit_q, w};
      endfunction

      function void walk(logic [3:0] s);
         int         n;
         int         m;
         int         u;
         int         nxt;
         int         id;
         int         slot;
         int         here;
         bit         hit;
         bit         used [EDGE_CAP];
         bit         par [VERT_CAP];
         int         cur [VERT_CAP];
         logic [3:0] stk [$];
         logic [3:0] circ [$];
         n = live();
         m = edge_count;
         if (n == 0 || rejected) begin
            push('0, 1'b0, 1'b1);
            return;
         end
         if (m == 0) begin
            if (n > 1) push('0, 1'b0, 1'b1);
            else push('0, 1'b1, 1'b1);
            return;
         end
         if (s >= n) begin
            push('0, 1'b0, 1'b1);
            return;
         end
         for (int i = 0; i < EDGE_CAP; i++) used[i] = 0;
         for (int i = 0; i < VERT_CAP; i++) begin
            par[i] = 0;
            cur[i] = 0;
         end
         for (int i = 0; i < m; i++) begin
            if (end_a[i] >= n || end_b[i] >= n) begin
               push('0, 1'b0, 1'b1);
               return;
            end
            par[end_a[i]] ^= 1'b1;
            par[end_b[i]] ^= 1'b1;
         end
         for (int i = 0; i < n; i++)
            if (par[i]) begin
               push('0, 1'b0, 1'b1);
               return;
            end
         stk = {stk, s};
         while (stk.size() > 0) begin
            u = stk[$];
            hit = 0;
            nxt = 0;
            id = 0;
            while (cur[u] < 2 * m && !hit) begin
               slot = cur[u];
               here = slot[0] ? end_b[slot >> 1] : end_a[slot >> 1];
               if (here == u && !used[slot >> 1]) begin
                  hit = 1;
                  id = slot >> 1;
                  nxt = slot[0] ? end_a[id] : end_b[id];
               end
               cur[u]++;
            end
            if (!hit) begin
               circ = {circ, 4'(u)};
               void'(stk.pop_back());
            end else begin
               used[id] = 1;
               stk = {stk, 4'(nxt)};
            end
         end
         for (int i = 0; i < m; i++)
            if (!used[i]) begin
               push('0, 1'b0, 1'b1);
               return;
            end
         foreach (circ[i]) push(circ[i], 1'b1, i == circ.size() - 1);
      endfunction

      function void note_word(ecf_pkg::req_type r);
         case (r.op)
            ecf_pkg::OP_ADD: begin
               if (r.first_end >= live() || r.second_end >= live() ||
                   edge_count >= EDGE_CAP) begin
                  rejected = 1;
               end else begin
                  end_a[edge_count] = r.first_end;
                  end_b[edge_count] = r.second_end;
                  edge_count++;
               end
            end
            ecf_pkg::OP_RUN: walk(r.start_vertex);
            ecf_pkg::OP_CLEAR: begin
               edge_count = 0;
               rejected = 0;
            end
            default: ;
         endcase
      endfunction

      task report(string what, int got, int want);
         $display("mismatch %s: got %0d want %0d", what, got, want);
         errors++;
      endtask

      task check_word(ecf_pkg::rsp_type got);
         ecf_pkg::rsp_type want;
         if (circuit_q.size() == 0) begin
            report("unexpected word vertex", got.vertex, -1);
            return;
         end
         want = circuit_q.pop_front();
         if (got.vertex !== want.vertex) report("vertex", got.vertex, want.vertex);
         if (got.found !== want.found) report("found", got.found, want.found);
         if (got.last !== want.last) report("last", got.last, want.last);
      endtask
   endclass

   logic             clock = 0;
   logic             reset = 1;
   logic             start = 0;
   logic             busy;
   ecf_pkg::req_type req_data = '0;
   logic             rsp_strobe;
   ecf_pkg::rsp_type rsp_data;
   logic             csr_write_enable = 0;
   logic [4:0]       csr_write_data = '0;

   circuit_scoreboard sb = new();
   int items = 0;
   bit burst = 0;

   euler_circuit_finder DUT (
      .clock(clock),
      .reset(reset),
      .start(start),
      .busy(busy),
      .req_data(req_data),
      .rsp_strobe(rsp_strobe),
      .rsp_data(rsp_data),
      .csr_write_enable(csr_write_enable),
      .csr_write_data(csr_write_data)
   );

   initial begin
      forever #1 clock = ~clock;
   end

   always @(posedge clock) begin
      if (!reset && rsp_strobe === 1'b1) sb.check_word(rsp_data);
   end

   function automatic ecf_pkg::req_type word(logic [1:0] op, int a, int b, int s);
      ecf_pkg::req_type r;
      r.op = op;
      r.first_end = 4'(a);
      r.second_end = 4'(b);
      r.start_vertex = 4'(s);
      return r;
   endfunction

   task automatic send(input ecf_pkg::req_type r);
      int gap;
      start <= 1'b1;
      req_data <= r;
      do @(posedge clock); while (busy);
      sb.note_word(r);
      if (r.op != OP_UNUSED) items++;
      @(negedge clock);
      gap = burst ? 0 : $urandom_range(0, 14);
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(negedge clock);
      end
   endtask

   // hold until every expected word is out and the block is idle
   task automatic settle();
      start <= 1'b0;
      while (sb.pending() > 0 || busy) @(negedge clock);
      repeat (10) @(negedge clock);
   endtask

   task automatic write_count(input int v);
      settle();
      csr_write_enable <= 1'b1;
      csr_write_data <= 5'(v);
      @(negedge clock);
      csr_write_enable <= 1'b0;
      sb.vcount = 5'(v);
   endtask

   initial begin
      int n;
      int k;
      int v0;
      int cur;
      int nx;
      int pick;
      repeat (12) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      send(word(ecf_pkg::OP_RUN, 0, 0, 0));
      write_count(1);
      send(word(ecf_pkg::OP_RUN, 0, 0, 15));
      send(word(ecf_pkg::OP_ADD, 0, 0, 0));
      send(word(ecf_pkg::OP_RUN, 0, 0, 0));
      write_count(31);
      send(word(ecf_pkg::OP_CLEAR, 0, 0, 0));
      send(word(ecf_pkg::OP_ADD, 15, 0, 0));
      send(word(ecf_pkg::OP_ADD, 0, 15, 15));
      send(word(ecf_pkg::OP_ADD, 7, 7, 0));
      send(word(ecf_pkg::OP_RUN, 0, 0, 15));
      send(word(ecf_pkg::OP_ADD, 3, 5, 0));
      send(word(ecf_pkg::OP_RUN, 0, 0, 0));
      send(word(OP_UNUSED, 15, 15, 15));
      write_count(3);
      send(word(ecf_pkg::OP_CLEAR, 0, 0, 0));
      send(word(ecf_pkg::OP_ADD, 0, 1, 0));
      send(word(ecf_pkg::OP_ADD, 1, 2, 0));
      send(word(ecf_pkg::OP_ADD, 2, 0, 0));
      send(word(ecf_pkg::OP_RUN, 0, 0, 2));
      write_count(2);
      send(word(ecf_pkg::OP_RUN, 0, 0, 0));
      send(word(ecf_pkg::OP_CLEAR, 0, 0, 0));
      send(word(ecf_pkg::OP_ADD, 0, 1, 0));
      send(word(ecf_pkg::OP_ADD, 1, 0, 0));
      send(word(ecf_pkg::OP_RUN, 0, 0, 9));
      send(word(ecf_pkg::OP_ADD, 5, 0, 0));
      send(word(ecf_pkg::OP_RUN, 0, 0, 0));
      write_count(16);
      send(word(ecf_pkg::OP_CLEAR, 0, 0, 0));
      send(word(ecf_pkg::OP_ADD, 0, 1, 0));
      send(word(ecf_pkg::OP_ADD, 1, 0, 0));
      send(word(ecf_pkg::OP_ADD, 2, 3, 0));
      send(word(ecf_pkg::OP_ADD, 3, 2, 0));
      send(word(ecf_pkg::OP_RUN, 0, 0, 0));

      while (items < 450) begin
         burst = ($urandom_range(0, 3) == 0);
         if ($urandom_range(0, 3) == 0) begin
            pick = $urandom_range(0, 9);
            if (pick == 0) write_count(0);
            else if (pick == 1) write_count($urandom_range(17, 31));
            else if (pick == 2) write_count(16);
            else write_count($urandom_range(1, 16));
         end
         if ($urandom_range(0, 4) != 0) send(word(ecf_pkg::OP_CLEAR, 0, 0, 0));
         n = sb.live();
         k = ($urandom_range(0, 11) == 0) ? $urandom_range(28, 34) : $urandom_range(1, 8);
         if (n > 0) begin
            v0 = $urandom_range(0, n - 1);
            cur = v0;
            for (int i = 0; i < k; i++) begin
               nx = (i == k - 1) ? v0 : $urandom_range(0, n - 1);
               if ($urandom_range(0, 1))
                  send(word(ecf_pkg::OP_ADD, cur, nx, $urandom_range(0, 15)));
               else
                  send(word(ecf_pkg::OP_ADD, nx, cur, $urandom_range(0, 15)));
               if ($urandom_range(0, 19) == 0)
                  send(ecf_pkg::req_type'($urandom_range(0, 16383)));
               cur = nx;
            end
         end
         if ($urandom_range(0, 6) == 0) send(word(ecf_pkg::OP_ADD, $urandom_range(0, 15),
                                                  $urandom_range(0, 15), 0));
         if (n > 0 && $urandom_range(0, 5) != 0)
            send(word(ecf_pkg::OP_RUN, $urandom_range(0, 15), $urandom_range(0, 15),
                      $urandom_range(0, n - 1)));
         else
            send(word(ecf_pkg::OP_RUN, 0, 0, $urandom_range(0, 15)));
         if ($urandom_range(0, 9) == 0) settle();
      end

      settle();
      repeat (50) @(negedge clock);
      if (sb.errors == 0 && sb.pending() == 0) $display("SCOREBOARD CLEAN");
      else $display("SCOREBOARD MISMATCH");
      $finish;
   end

   initial begin
      #40000000;
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule
